// ===== rtl/b5gc_pkg.sv =====
`default_nettype none
package b5gc_pkg;

	localparam int CACHE_SLOTS = 64;
	localparam int FONT_WORDS  = 65536;

	localparam int SLOT_W  = $clog2(CACHE_SLOTS);
	localparam int SLOT_XW = (SLOT_W > 6) ? SLOT_W : 6;
	localparam int FONT_AW = $clog2(FONT_WORDS);
	localparam int GSTORE_AW = SLOT_W + 2;
	localparam logic [20:0] FONT_BYTE_LIMIT = 21'(FONT_WORDS * 8);

	localparam logic MODE_RESOLVE = 1'b0;
	localparam logic MODE_LOAD    = 1'b1;

	localparam logic [1:0] ST_HIT    = 2'd0;
	localparam logic [1:0] ST_FILLED = 2'd1;
	localparam logic [1:0] ST_BADCODE = 2'd2;
	localparam logic [1:0] ST_BEYOND = 2'd3;

	localparam logic [7:0] LEAD_MIN     = 8'hA1;
	localparam logic [7:0] TRAIL_LO_MIN = 8'h40;
	localparam logic [7:0] TRAIL_LO_MAX = 8'h7E;
	localparam logic [7:0] TRAIL_HI_MIN = 8'hA1;
	localparam logic [7:0] TRAIL_HI_MAX = 8'hFE;
	localparam logic [7:0] TRAIL_HI_OFF = 8'h62;
	localparam logic [14:0] GLYPHS_PER_ROW = 15'd157;
	localparam logic [19:0] GLYPH_BYTES = 20'd32;

	typedef struct packed {
		logic        mode;
		logic [15:0] char_code;
		logic [15:0] load_word_address;
		logic [63:0] load_word_data;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  slot;
		logic [63:0] glyph_word;
		logic [1:0]  word_number;
		logic        last;
	} out_beat_t;

	typedef struct packed {
		logic [15:0] code;
		logic        fill;
	} cell_ctl_t;

	typedef struct packed {
		logic        bad;
		logic        beyond;
		logic [15:0] base;
	} idx_t;

	function automatic logic [5:0] slot6(input logic [SLOT_W-1:0] idx);
		logic [SLOT_XW-1:0] tmp;
		tmp = SLOT_XW'(idx);
		return tmp[5:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/b5gc_tag_cell.sv =====
`default_nettype none
module b5gc_tag_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              first,
	input  wire b5gc_pkg::cell_ctl_t ctl,
	input  wire logic              tok_in,
	output logic                   tok_out,
	output logic                   match
);

	logic        valid_q;
	logic        tok_q;
	logic        match_q;
	logic [15:0] tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= first;
			match_q <= 1'b0;
		end else begin
			match_q <= valid_q && (tag_q == ctl.code);
			if (ctl.fill) begin
				if (tok_q) begin
					valid_q <= 1'b1;
				end
				tok_q <= tok_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fill && tok_q) begin
			tag_q <= ctl.code;
		end
	end

	assign tok_out = tok_q;
	assign match   = match_q;

endmodule
`default_nettype wire

// ===== rtl/b5gc_hit_encoder.sv =====
`default_nettype none
module b5gc_hit_encoder (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [b5gc_pkg::CACHE_SLOTS-1:0] match,
	output logic                                  hit,
	output logic [b5gc_pkg::SLOT_W-1:0]           slot
);

	localparam int GRP = 16;
	localparam int NG  = (b5gc_pkg::CACHE_SLOTS + GRP - 1) / GRP;
	localparam int PW  = NG * GRP;

	logic [PW-1:0]  pad;
	logic [NG-1:0]  any_s1;
	logic [3:0]     low_s1 [NG];
	logic [NG-1:0]  any_c;
	logic [3:0]     low_c [NG];
	logic           hit_q;
	logic [b5gc_pkg::SLOT_W-1:0] slot_q;
	logic           hit_c;
	logic [b5gc_pkg::SLOT_W-1:0] slot_c;

	assign pad = PW'(match);

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			any_c[g] = |pad[g*GRP +: GRP];
			low_c[g] = 4'd0;
			for (int b = GRP - 1; b >= 0; b--) begin
				if (pad[g*GRP + b]) begin
					low_c[g] = 4'(b);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_s1 <= '0;
		end else begin
			any_s1 <= any_c;
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < NG; g++) begin
			low_s1[g] <= low_c[g];
		end
	end

	always_comb begin
		hit_c  = 1'b0;
		slot_c = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (any_s1[g]) begin
				hit_c  = 1'b1;
				slot_c = b5gc_pkg::SLOT_W'(g * GRP + int'(low_s1[g]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= hit_c;
		end
	end

	always_ff @(posedge clk) begin
		slot_q <= slot_c;
	end

	assign hit  = hit_q;
	assign slot = slot_q;

endmodule
`default_nettype wire

// ===== rtl/b5gc_index_calc.sv =====
`default_nettype none
module b5gc_index_calc (
	input  wire logic        clk,
	input  wire logic [15:0] code,
	input  wire logic [19:0] font_len,
	output b5gc_pkg::idx_t   idx
);

	logic [7:0]  lead;
	logic [7:0]  trail;
	logic        t_lo;
	logic        t_hi;
	logic        bad_s1;
	logic [6:0]  lead_off_s1;
	logic [7:0]  trail_idx_s1;
	logic        bad_s2;
	logic [14:0] gidx_s2;
	logic [19:0] end_bytes;
	b5gc_pkg::idx_t idx_s3;

	assign lead  = code[15:8];
	assign trail = code[7:0];
	assign t_lo  = (trail >= b5gc_pkg::TRAIL_LO_MIN) && (trail <= b5gc_pkg::TRAIL_LO_MAX);
	assign t_hi  = (trail >= b5gc_pkg::TRAIL_HI_MIN) && (trail <= b5gc_pkg::TRAIL_HI_MAX);

	always_ff @(posedge clk) begin
		bad_s1       <= (lead < b5gc_pkg::LEAD_MIN) || !(t_lo || t_hi);
		lead_off_s1  <= 7'(lead - b5gc_pkg::LEAD_MIN);
		trail_idx_s1 <= t_lo ? (trail - b5gc_pkg::TRAIL_LO_MIN)
		                     : (trail - b5gc_pkg::TRAIL_HI_OFF);
		bad_s2       <= bad_s1;
		gidx_s2      <= 15'(15'(lead_off_s1) * b5gc_pkg::GLYPHS_PER_ROW)
		                + 15'(trail_idx_s1);
	end

	assign end_bytes = {gidx_s2, 5'b0} + b5gc_pkg::GLYPH_BYTES;

	always_ff @(posedge clk) begin
		idx_s3.bad    <= bad_s2;
		idx_s3.beyond <= ({1'b0, end_bytes} > {1'b0, font_len})
		                 || ({1'b0, end_bytes} > b5gc_pkg::FONT_BYTE_LIMIT);
		idx_s3.base   <= 16'({gidx_s2, 2'b00});
	end

	assign idx = idx_s3;

endmodule
`default_nettype wire

// ===== rtl/big5_glyph_cache.sv =====
// Big5 glyph cache.
// Input channel in_valid/in_ready/in_data: a load beat (mode 1) writes one
// 64-bit font word and gives no result; a resolve beat (mode 0) looks up a
// Big5 code in a fully associative cache of tag cells with FIFO refill.
// Output channel out_valid/out_ready/out_data: a resolved glyph leaves as
// four beats (word_number 0..3, last on the fourth); a failed lookup gives
// one beat with status 2 or 3 and last set.
// APB port: register 0 (font_length_bytes) at byte address 0.
// Load beats are written to the font memory on acceptance and leave the
// input ready. A resolve beat passes through tag compare and priority
// encode (states MATCH, ENC1, ENC2), a decision state (DECIDE), then for
// each glyph word a memory read (ISSUE) and an output register load (PUT);
// a failure beat is loaded in DECIDE. The input is not ready again until
// the sequencer has returned to idle. Glyph words come from the glyph
// memory on a hit and from the font memory on a miss.
// At reset the cache is empty, the fill pointer is zero and the font length
// is zero; no clearing pass is needed. When the receiver stalls, the output
// register holds its beat and the sequencer waits before issuing the next
// word; no beat is dropped.
`default_nettype none
module big5_glyph_cache (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire b5gc_pkg::in_beat_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output b5gc_pkg::out_beat_t      out_data,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [2:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_MATCH  = 7'b0000010,
		S_ENC1   = 7'b0000100,
		S_ENC2   = 7'b0001000,
		S_DECIDE = 7'b0010000,
		S_ISSUE  = 7'b0100000,
		S_PUT    = 7'b1000000
	} state_t;

	state_t state_q;
	logic [19:0] font_len_q;
	logic [15:0] code_q;
	logic [1:0]  w_q;
	logic        miss_q;
	logic [b5gc_pkg::SLOT_W-1:0] sel_slot_q;
	logic [b5gc_pkg::SLOT_W-1:0] fill_q;
	logic        out_valid_q;
	b5gc_pkg::out_beat_t out_q;

	logic [63:0] font_mem  [b5gc_pkg::FONT_WORDS];
	logic [63:0] glyph_mem [b5gc_pkg::CACHE_SLOTS * 4];
	logic [63:0] font_rd_q;
	logic [63:0] glyph_rd_q;

	logic in_acc;
	logic out_free;
	logic out_load;
	logic font_we;
	logic issue;
	logic fill;
	logic fail;
	logic [1:0] fail_status;
	logic [b5gc_pkg::FONT_AW-1:0] font_ra;
	logic [b5gc_pkg::GSTORE_AW-1:0] glyph_a;

	b5gc_pkg::cell_ctl_t ctl;
	logic [b5gc_pkg::CACHE_SLOTS-1:0] tok;
	logic [b5gc_pkg::CACHE_SLOTS-1:0] match;
	logic hit;
	logic [b5gc_pkg::SLOT_W-1:0] hit_slot;
	b5gc_pkg::idx_t idx;

	assign ctl.code = code_q;
	assign ctl.fill = fill;

	for (genvar i = 0; i < b5gc_pkg::CACHE_SLOTS; i++) begin : g_cell
		b5gc_tag_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.first   (i == 0),
			.ctl     (ctl),
			.tok_in  (tok[(i + b5gc_pkg::CACHE_SLOTS - 1) % b5gc_pkg::CACHE_SLOTS]),
			.tok_out (tok[i]),
			.match   (match[i])
		);
	end

	b5gc_hit_encoder u_enc (
		.clk    (clk),
		.arst_n (arst_n),
		.match  (match),
		.hit    (hit),
		.slot   (hit_slot)
	);

	b5gc_index_calc u_idx (
		.clk      (clk),
		.code     (code_q),
		.font_len (font_len_q),
		.idx      (idx)
	);

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {12'b0, font_len_q} : 32'b0;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign font_we   = in_acc && (in_data.mode == b5gc_pkg::MODE_LOAD)
	                   && ({1'b0, in_data.load_word_address} < 17'(b5gc_pkg::FONT_WORDS));
	assign issue     = (state_q == S_ISSUE);
	assign fail      = !hit && (idx.bad || idx.beyond);
	assign fail_status = idx.bad ? b5gc_pkg::ST_BADCODE : b5gc_pkg::ST_BEYOND;
	assign fill      = (state_q == S_DECIDE) && !hit && !idx.bad && !idx.beyond;
	assign out_load  = ((state_q == S_DECIDE) && fail && out_free)
	                   || ((state_q == S_PUT) && out_free);
	assign font_ra   = idx.base[b5gc_pkg::FONT_AW-1:0] + b5gc_pkg::FONT_AW'(w_q);
	assign glyph_a   = {sel_slot_q, w_q};

	always_ff @(posedge clk) begin
		if (font_we) begin
			font_mem[in_data.load_word_address[b5gc_pkg::FONT_AW-1:0]] <= in_data.load_word_data;
		end
		if (issue && miss_q) begin
			font_rd_q <= font_mem[font_ra];
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_PUT) && out_free && miss_q) begin
			glyph_mem[glyph_a] <= font_rd_q;
		end
		if (issue && !miss_q) begin
			glyph_rd_q <= glyph_mem[glyph_a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			font_len_q  <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			w_q         <= '0;
			miss_q      <= 1'b0;
		end else begin
			if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
				font_len_q <= pwdata[19:0];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fill) begin
				fill_q <= (fill_q == b5gc_pkg::SLOT_W'(b5gc_pkg::CACHE_SLOTS - 1))
				          ? '0 : fill_q + 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && (in_data.mode == b5gc_pkg::MODE_RESOLVE)) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH:  state_q <= S_ENC1;
				S_ENC1:   state_q <= S_ENC2;
				S_ENC2:   state_q <= S_DECIDE;
				S_DECIDE: begin
					w_q    <= '0;
					miss_q <= !hit;
					if (!fail) begin
						state_q <= S_ISSUE;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_ISSUE:  state_q <= S_PUT;
				S_PUT: begin
					if (out_free) begin
						w_q     <= w_q + 1'b1;
						state_q <= (w_q == 2'd3) ? S_IDLE : S_ISSUE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			code_q <= in_data.char_code;
		end
		if (state_q == S_DECIDE) begin
			sel_slot_q <= hit ? hit_slot : fill_q;
		end
		if (out_load) begin
			if (state_q == S_DECIDE) begin
				out_q.status      <= fail_status;
				out_q.slot        <= '0;
				out_q.glyph_word  <= '0;
				out_q.word_number <= '0;
				out_q.last        <= 1'b1;
			end else begin
				out_q.status      <= miss_q ? b5gc_pkg::ST_FILLED : b5gc_pkg::ST_HIT;
				out_q.slot        <= b5gc_pkg::slot6(sel_slot_q);
				out_q.glyph_word  <= miss_q ? font_rd_q : glyph_rd_q;
				out_q.word_number <= w_q;
				out_q.last        <= (w_q == 2'd3);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_busy_after_resolve: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.mode == b5gc_pkg::MODE_RESOLVE) |=> !in_ready)
		else $error("resolve beat did not block the input");

	a_fail_beat_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((out_data.status == b5gc_pkg::ST_BADCODE)
		|| (out_data.status == b5gc_pkg::ST_BEYOND))
		|-> out_data.last && (out_data.glyph_word == 64'd0))
		else $error("failure beat carries data or lacks last");

	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= b5gc_pkg::SLOT_W'(b5gc_pkg::CACHE_SLOTS - 1))
		else $error("fill pointer out of range");

endmodule
`default_nettype wire
